/* sv/mtg_pkg.sv */
`timescale 1ns / 1ps
// mtg_pkg: shared constants, types and state codes of the mt19937 generator
package mtg_pkg;

    localparam int STATE_WORDS   = 624;
    localparam int MIDDLE_OFFSET = 397;
    localparam int WORD_W        = 32;
    localparam int IDX_W         = $clog2(STATE_WORDS);

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [IDX_W-1:0]  t_idx;

    localparam t_word TWIST_MATRIX = 32'h9908_B0DF;
    localparam t_word SEED_MULT    = 32'd69069;
    localparam t_word TEMPER_B     = 32'h9D2C_5680;
    localparam t_word TEMPER_C     = 32'hEFC6_0000;
    localparam t_word DEFAULT_SEED = 32'd4357;
    localparam t_word UPPER_MASK   = 32'h8000_0000;
    localparam t_word LOWER_MASK   = 32'h7FFF_FFFF;

    localparam t_idx LAST_IDX = t_idx'(STATE_WORDS - 1);

    typedef enum logic [1:0] {
        S_SEED,
        S_IDLE,
        S_CALC
    } t_state;

endpackage

/* sv/mersenne_twister_generator.sv */
`timescale 1ns / 1ps
// mersenne_twister_generator: mt19937 generator with memory-held state
//
//   channel  | direction | handshake                  | payload
//   draw     | in        | i_draw_valid / o_draw_stall | i_draw_request (1b)
//   word     | out       | o_word_valid / i_word_stall | o_random_word (32b)
//   seed     | in        | i_seed_valid / o_seed_ready | i_seed_value (32b)
//
// a draw first reads the next and middle words from the dual-read state ram,
// then twists, writes back and loads the output register
// reset and every seed write run a seeding pass over all 624 ram words, one
// word per cycle through the 69069 multiplier; draws are stalled meanwhile
// a draw accepted while a result waits in the output register holds in the
// twist step until that result is taken
module mersenne_twister_generator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_draw_valid,
    output logic                o_draw_stall,
    input  logic                i_draw_request,
    output logic                o_word_valid,
    input  logic                i_word_stall,
    output mtg_pkg::t_word      o_random_word,
    input  logic                i_seed_valid,
    output logic                o_seed_ready,
    input  mtg_pkg::t_word      i_seed_value
);

    mtg_pkg::t_state r_state, n_state;
    mtg_pkg::t_idx   r_idx, n_idx;
    mtg_pkg::t_idx   r_k, n_k;
    mtg_pkg::t_word  r_x, n_x;
    mtg_pkg::t_word  r_cur, n_cur;
    mtg_pkg::t_word  r_out, n_out;
    logic            r_out_valid, n_out_valid;

    logic            draw_xfer;
    logic            word_xfer;
    logic            seed_xfer;
    logic            calc_go;
    logic            ram_we;
    mtg_pkg::t_idx   ram_waddr;
    mtg_pkg::t_word  ram_wdata;
    mtg_pkg::t_idx   nxt_idx;
    mtg_pkg::t_idx   mid_idx;
    logic [mtg_pkg::IDX_W:0] mid_sum;
    mtg_pkg::t_word  rd_nxt;
    mtg_pkg::t_word  rd_mid;
    mtg_pkg::t_word  twisted;
    mtg_pkg::t_word  tempered;

    assign draw_xfer = i_draw_valid && !o_draw_stall;
    assign word_xfer = o_word_valid && !i_word_stall;
    assign seed_xfer = i_seed_valid && o_seed_ready;

    // neighbor addresses of the current word, wrapped at the table end
    assign nxt_idx = (r_idx == mtg_pkg::LAST_IDX) ? '0 : r_idx + 1'b1;
    assign mid_sum = {1'b0, r_idx} + (mtg_pkg::IDX_W + 1)'(mtg_pkg::MIDDLE_OFFSET);
    assign mid_idx = (mid_sum >= (mtg_pkg::IDX_W + 1)'(mtg_pkg::STATE_WORDS))
                   ? mtg_pkg::t_idx'(mid_sum - (mtg_pkg::IDX_W + 1)'(mtg_pkg::STATE_WORDS))
                   : mtg_pkg::t_idx'(mid_sum);

    mtg_state_ram #(
        .DEPTH (mtg_pkg::STATE_WORDS),
        .WIDTH (mtg_pkg::WORD_W),
        .ADDR_W(mtg_pkg::IDX_W)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_waddr  (ram_waddr),
        .i_wdata  (ram_wdata),
        .i_re     (draw_xfer && i_draw_request),
        .i_raddr_a(nxt_idx),
        .i_raddr_b(mid_idx),
        .o_rdata_a(rd_nxt),
        .o_rdata_b(rd_mid)
    );

    mtg_twist_unit u_twist (
        .i_cur     (r_cur),
        .i_nxt     (rd_nxt),
        .i_mid     (rd_mid),
        .o_twisted (twisted),
        .o_tempered(tempered)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mtg_pkg::S_SEED;
            r_idx       <= '0;
            r_k         <= '0;
            r_x         <= mtg_pkg::DEFAULT_SEED | 32'd1;
            r_cur       <= mtg_pkg::DEFAULT_SEED | 32'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_k         <= n_k;
            r_x         <= n_x;
            r_cur       <= n_cur;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_k         = r_k;
        n_x         = r_x;
        n_cur       = r_cur;
        n_out       = r_out;
        n_out_valid = r_out_valid && !word_xfer;
        calc_go     = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = twisted;
        o_draw_stall = 1'b1;
        o_seed_ready = 1'b0;

        unique case (r_state)
            mtg_pkg::S_SEED: begin
                ram_we    = 1'b1;
                ram_waddr = r_k;
                ram_wdata = r_x;
                n_x       = r_x * mtg_pkg::SEED_MULT;
                n_k       = r_k + 1'b1;
                if (r_k == mtg_pkg::LAST_IDX) begin
                    n_state = mtg_pkg::S_IDLE;
                    n_k     = '0;
                end
            end
            mtg_pkg::S_IDLE: begin
                // a pending seed transfer goes first, draws wait for it
                o_draw_stall = i_seed_valid;
                o_seed_ready = 1'b1;
                if (seed_xfer) begin
                    // restart a seeding pass, word 0 gets the odd seed
                    n_state = mtg_pkg::S_SEED;
                    n_k     = '0;
                    n_x     = i_seed_value | 32'd1;
                    n_cur   = i_seed_value | 32'd1;
                    n_idx   = '0;
                end else if (draw_xfer && i_draw_request) begin
                    n_state = mtg_pkg::S_CALC;
                end
            end
            mtg_pkg::S_CALC: begin
                // wait while the output register still holds an untaken word
                calc_go = !r_out_valid || word_xfer;
                if (calc_go) begin
                    ram_we      = 1'b1;
                    n_out       = tempered;
                    n_out_valid = 1'b1;
                    n_cur       = rd_nxt;
                    n_idx       = nxt_idx;
                    n_state     = mtg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mtg_pkg::S_IDLE;
            end
        endcase
    end

    assign o_word_valid  = r_out_valid;
    assign o_random_word = r_out;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= mtg_pkg::LAST_IDX)
        else $error("word index past table end");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mtg_pkg::S_IDLE) |-> !ram_we)
        else $error("state ram written while idle");

    a_calc_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mtg_pkg::S_CALC && calc_go) |=> o_word_valid)
        else $error("twisted word not loaded into output register");

    a_seed_starts_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seed_xfer |=> (r_state == mtg_pkg::S_SEED && r_k == '0))
        else $error("seed write did not start a seeding pass");

    a_draw_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mtg_pkg::S_SEED || r_state == mtg_pkg::S_CALC) |-> o_draw_stall)
        else $error("draw taken while busy");

endmodule

/* sv/mtg_state_ram.sv */
`timescale 1ns / 1ps
// mtg_state_ram: generic ram with one write port and two registered read ports
module mtg_state_ram #(
    parameter int DEPTH  = 624,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_a,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= mem[i_raddr_a];
            o_rdata_b <= mem[i_raddr_b];
        end
    end

endmodule

/* sv/mtg_twist_unit.sv */
`timescale 1ns / 1ps
// mtg_twist_unit: twist of one state word and tempering of the result
module mtg_twist_unit (
    input  mtg_pkg::t_word i_cur,
    input  mtg_pkg::t_word i_nxt,
    input  mtg_pkg::t_word i_mid,
    output mtg_pkg::t_word o_twisted,
    output mtg_pkg::t_word o_tempered
);

    mtg_pkg::t_word mixed;
    mtg_pkg::t_word w;
    mtg_pkg::t_word y1;
    mtg_pkg::t_word y2;
    mtg_pkg::t_word y3;

    always_comb begin
        mixed = (i_cur & mtg_pkg::UPPER_MASK) | (i_nxt & mtg_pkg::LOWER_MASK);
        w     = i_mid ^ (mixed >> 1) ^ (i_nxt[0] ? mtg_pkg::TWIST_MATRIX : '0);
        y1    = w ^ (w >> 11);
        y2    = y1 ^ ((y1 << 7) & mtg_pkg::TEMPER_B);
        y3    = y2 ^ ((y2 << 15) & mtg_pkg::TEMPER_C);
    end

    assign o_twisted  = w;
    assign o_tempered = y3 ^ (y3 >> 18);

endmodule
